/* src/atan2_pkg.sv */
// Package: shared widths and constants for the rational atan2 core.
`timescale 1ns / 1ps
`default_nettype none
package atan2_pkg;
  localparam int unsigned InputWidthDef = 16;
  localparam int unsigned AngleFracDef  = 13;
  localparam longint unsigned DecScale  = 64'd100000000;
  localparam longint unsigned PiDec     = 64'd314159265;
  localparam longint unsigned HalfPiDec = 64'd157079633;
endpackage
`default_nettype wire

/* src/atan2_div.sv */
// Pipelined restoring divider: rounded quotient of num * 2^FRAC / den, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module atan2_div #(
  parameter int unsigned NumWidth = 80,
  parameter int unsigned Frac     = 13,
  parameter int unsigned QWidth   = 17,
  parameter int unsigned TagWidth = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [NumWidth-1:0] num_i,
  input  wire logic [NumWidth-1:0] den_i,
  input  wire logic [TagWidth-1:0] tag_i,
  output logic                     valid_o,
  output logic [QWidth-1:0]        quot_o,
  output logic [TagWidth-1:0]      tag_o
);
  // Integer part needs 3 bits (value below 8), then Frac bits, then one round bit.
  localparam int unsigned Steps = Frac + 4;
  localparam int unsigned RW    = NumWidth + 1;

  logic [Steps:1]               vld_q;
  logic [RW-1:0]                rem_q [1:Steps];
  logic [NumWidth-1:0]          den_q [1:Steps];
  logic [Steps-1:0]             quo_q [1:Steps];
  logic [TagWidth-1:0]          tag_q [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    // Three integer steps compare against den shifted; we instead compare
    // against den << (2 - s) for the first three stages.
    localparam int unsigned Sh = (s < 3) ? (2 - s) : 0;
    logic                vin;
    logic [RW-1:0]       rem_in;
    logic [NumWidth-1:0] den_in;
    logic [Steps-1:0]    quo_in;
    logic [TagWidth-1:0] tag_in;
    logic [RW+2:0]       dsh, rin, diff;
    logic                ge;
    if (s == 0) begin : g_head
      assign vin    = valid_i;
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_link
      assign vin    = vld_q[s];
      assign rem_in = rem_q[s];
      assign den_in = den_q[s];
      assign quo_in = quo_q[s];
      assign tag_in = tag_q[s];
    end
    always_comb begin
      dsh  = {3'b0, 1'b0, den_in} << Sh;
      rin  = (s < 3) ? {3'b0, rem_in} : {3'b0, rem_in} << 1;
      ge   = rin >= dsh;
      diff = ge ? rin - dsh : rin;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= diff[RW-1:0];
        den_q[s+1] <= den_in;
        quo_q[s+1] <= {quo_in[Steps-2:0], ge};
        tag_q[s+1] <= tag_in;
      end
    end
  end

  // Last bit is the round bit: add it to the truncated quotient.
  logic [Steps-1:0] qfull;
  assign qfull   = {1'b0, quo_q[Steps][Steps-1:1]} + {{(Steps-1){1'b0}}, quo_q[Steps][0]};
  assign quot_o  = QWidth'(qfull);
  assign valid_o = vld_q[Steps];
  assign tag_o   = tag_q[Steps];
endmodule
`default_nettype wire

/* src/atan2_rational_approx_core.sv */
// Top level: streaming rational ("0.28") atan2 approximation, deep pipeline.
// Usage:
//  - Slave channel s_axis_*: one beat carries an (y, x) pair in tdata,
//    y_value in the low INPUT_WIDTH bits and x_value above it.
//  - Master channel m_axis_*: one beat per input beat carries angle_q13,
//    signed radians with ANGLE_FRAC_BITS fraction bits, saturated to +-pi.
//  - Throughput: one beat per cycle while m_axis_tready does not stall. Depth:
//    four arithmetic stages, one divider stage per quotient bit, one
//    output stage; the divider bit loop sets the depth.
//  - The whole pipeline advances only when the output register is empty or
//    being drained, so a stall on m_axis_tready freezes every stage; no
//    beat is lost or repeated. s_axis_tready follows that advance enable.
//  - Reset clears all valid bits; data registers are not reset.
//  - Arithmetic: tmag = 25|x||y|, den = 25 big^2 + 7 small^2, numerator
//    |offset*den +- tmag*1e8| over den*1e8, rounded half away from zero.
`timescale 1ns / 1ps
`default_nettype none
module atan2_rational_approx_core #(
  parameter int unsigned INPUT_WIDTH     = atan2_pkg::InputWidthDef,
  parameter int unsigned ANGLE_FRAC_BITS = atan2_pkg::AngleFracDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [INPUT_WIDTH-1:0] y_value, above it x_value, zero padded
  input  wire logic [((2*INPUT_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [ANGLE_FRAC_BITS+2:0] angle_q13, zero padded
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]    m_axis_tdata
);
  import atan2_pkg::*;

  localparam int unsigned W   = INPUT_WIDTH;
  localparam int unsigned OW  = ANGLE_FRAC_BITS + 3;
  localparam int unsigned OBW = ((OW+7)/8)*8;
  localparam int unsigned PW  = 2*W + 5;   // 25 * W^2 and sums
  localparam int unsigned NW  = PW + 30;   // times up to 1e8 / pi
  localparam longint unsigned PiQ =
    ((PiDec << ANGLE_FRAC_BITS) + DecScale/2) / DecScale;

  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: magnitudes and branch.
  logic signed [W-1:0] y_in, x_in;
  assign y_in = s_axis_tdata[W-1:0];
  assign x_in = s_axis_tdata[2*W-1:W];

  logic          v1_q, big_y_q, xneg_q, yneg_q, zero_q, xpos_q;
  logic [W:0]    ax_d, ay_d;
  assign ax_d = x_in[W-1] ? -{x_in[W-1], x_in} : {1'b0, x_in};
  assign ay_d = y_in[W-1] ? -{y_in[W-1], y_in} : {1'b0, y_in};

  logic [W:0] big1_q, sml1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      big_y_q <= !(ay_d < ax_d);
      big1_q  <= (ay_d < ax_d) ? ax_d : ay_d;
      sml1_q  <= (ay_d < ax_d) ? ay_d : ax_d;
      xneg_q  <= x_in[W-1];
      yneg_q  <= y_in[W-1];
      xpos_q  <= !x_in[W-1] && (x_in != '0);
      zero_q  <= (x_in == '0) && (y_in == '0);
    end
  end

  // Stage 2: squares and cross product.
  logic          v2_q, neg2_q, oneg2_q, zero2_q, big_y2_q, xpos2_q;
  logic [PW-1:0] den2_q, tmag2_q;
  logic [2*W+1:0] bb, ss, bs;
  assign bb = {1'b0, big1_q} * {1'b0, big1_q};
  assign ss = {1'b0, sml1_q} * {1'b0, sml1_q};
  assign bs = {1'b0, big1_q} * {1'b0, sml1_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      den2_q   <= PW'(bb) * PW'(25) + PW'(ss) * PW'(7);
      tmag2_q  <= PW'(bs) * PW'(25);
      neg2_q   <= big_y_q ? (xneg_q == yneg_q) : (xneg_q != yneg_q);
      oneg2_q  <= yneg_q;
      zero2_q  <= zero_q;
      big_y2_q <= big_y_q;
      xpos2_q  <= xpos_q;
    end
  end

  // Stage 3: scale by offset and by 1e8. The offset is one of two constants
  // (pi/2 or pi) or zero, so select between constant products.
  logic          v3_q, tneg3_q, oneg3_q, zero3_q;
  logic [NW-1:0] p1_q, p2_q, dd_q;
  logic          oneg, tneg;
  always_comb begin
    if (big_y2_q) begin
      oneg = oneg2_q;
    end else if (xpos2_q) begin
      oneg = 1'b0;
    end else begin
      oneg = oneg2_q;
    end
    tneg = neg2_q && (tmag2_q != '0);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= big_y2_q ? NW'(den2_q) * NW'(HalfPiDec) :
                 (xpos2_q ? '0 : NW'(den2_q) * NW'(PiDec));
      p2_q    <= NW'(tmag2_q) * NW'(DecScale);
      dd_q    <= NW'(den2_q) * NW'(DecScale);
      tneg3_q <= tneg;
      oneg3_q <= oneg;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: signed combine.
  logic          v4_q, neg4_q, zero4_q;
  logic [NW-1:0] num4_q, den4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      den4_q  <= zero3_q ? NW'(1) : dd_q;
      zero4_q <= zero3_q;
      if (oneg3_q == tneg3_q) begin
        num4_q <= p1_q + p2_q;
        neg4_q <= oneg3_q;
      end else if (p1_q >= p2_q) begin
        num4_q <= p1_q - p2_q;
        neg4_q <= oneg3_q;
      end else begin
        num4_q <= p2_q - p1_q;
        neg4_q <= tneg3_q;
      end
    end
  end

  // Divider stages.
  localparam int unsigned QW = ANGLE_FRAC_BITS + 4;
  logic          vq;
  logic [QW-1:0] quo;
  logic [1:0]    tagq;
  atan2_div #(
    .NumWidth(NW), .Frac(ANGLE_FRAC_BITS), .QWidth(QW), .TagWidth(2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (zero4_q ? NW'(0) : num4_q),
    .den_i   (den4_q),
    .tag_i   ({zero4_q, neg4_q}),
    .valid_o (vq),
    .quot_o  (quo),
    .tag_o   (tagq)
  );

  // Output register: saturate and apply sign.
  logic [QW-1:0]        qsat;
  logic signed [OW-1:0] ang_q;
  assign qsat = (quo > QW'(PiQ)) ? QW'(PiQ) : quo;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vq;
  end
  always_ff @(posedge clk_i) begin
    if (en) ang_q <= tagq[0] ? -OW'(qsat) : OW'(qsat);
  end
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OBW'($unsigned(ang_q));

`ifndef SYNTHESIS
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(ang_q) <= $signed(OW'(PiQ)) &&
                       $signed(ang_q) >= -$signed(OW'(PiQ))))
    else $error("angle beyond pi");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(ang_q) && v4_q == $past(v4_q))
    else $error("pipeline moved under stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq && tagq[1] |-> quo == '0)
    else $error("zero input gave nonzero angle");
`endif
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench for atan2_rational_approx_core: directed and random stimulus, scoreboard check.
`timescale 1ns / 1ps
module testbench;
  import atan2_pkg::*;

  localparam int unsigned FracBits  = AngleFracDef;
  localparam int          Latency   = FracBits + 9;
  localparam int          WatchLim  = 5000;
  localparam int          LongHold  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // [15:0] y_value, [31:16] x_value
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [15:0] angle_q13

  logic [15:0] angle_queue[$];
  int          mismatch_cnt;
  int          idle_cycles;
  bit          no_idle;
  bit          hold_req;

  atan2_rational_approx_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact rational angle: offset*den +- 25|x||y|*1e8 over den*1e8, rounded
  // half away from zero, clamped to +-pi.
  function automatic logic [15:0] rational_angle(logic signed [15:0] y, logic signed [15:0] x);
    logic [127:0] ax, ay, tmag, den, p1, p2, num, dd, scaled, rem, q, pi_q, omag;
    logic         tneg, oneg, neg;
    integer       xi, yi;
    xi = x;
    yi = y;
    ax = (xi < 0) ? -xi : xi;
    ay = (yi < 0) ? -yi : yi;
    pi_q = ((128'(PiDec) << FracBits) + DecScale / 2) / DecScale;
    if (xi == 0 && yi == 0) return 16'd0;
    tmag = ax * ay * 25;
    if (ay < ax) begin
      den  = ax * ax * 25 + ay * ay * 7;
      tneg = (xi < 0) != (yi < 0);
      if (xi > 0) begin
        omag = 0;
        oneg = 1'b0;
      end else begin
        omag = PiDec;
        oneg = (yi < 0);
      end
    end else begin
      den  = ay * ay * 25 + ax * ax * 7;
      tneg = !((xi < 0) != (yi < 0));
      omag = HalfPiDec;
      oneg = (yi < 0);
    end
    if (tmag == 0) tneg = 1'b0;
    p1 = den * omag;
    p2 = tmag * DecScale;
    if (oneg == tneg) begin
      num = p1 + p2;
      neg = oneg;
    end else if (p1 >= p2) begin
      num = p1 - p2;
      neg = oneg;
    end else begin
      num = p2 - p1;
      neg = tneg;
    end
    dd     = den * DecScale;
    scaled = num << FracBits;
    q      = scaled / dd;
    rem    = scaled % dd;
    if ((rem << 1) >= dd) q = q + 1;
    if (q > pi_q) q = pi_q;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Offer one (y, x) beat; valid stays high on return so back-to-back beats
  // never see a low-then-high pair in one step.
  task automatic send_pair(logic [15:0] y, logic [15:0] x);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {x, y};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    angle_queue.push_back(rational_angle(y, x));
  endtask

  // Drop valid at the edge that took the last beat, then wait for every angle.
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [15:0] pts[20][2];
    pts = '{'{16'sd0, 16'sd0}, '{16'sd1, 16'sd0}, '{-16'sd1, 16'sd0}, '{16'sd0, -16'sd1},
            '{16'sd0, 16'sd1}, '{16'sd0, 16'h8000}, '{16'h8000, 16'sd0},
            '{16'sd32767, 16'sd32767}, '{16'h8000, 16'h8000}, '{16'sd32767, 16'h8000},
            '{16'h8000, 16'sd32767}, '{16'sd5, 16'sd5}, '{-16'sd5, 16'sd5},
            '{16'sd5, -16'sd5}, '{-16'sd5, -16'sd5}, '{16'sd1, 16'h8000},
            '{-16'sd1, 16'h8000}, '{16'sd32767, 16'sd1}, '{16'sd1, 16'sd32767},
            '{16'h8000, -16'sd1}};
    foreach (pts[i]) send_pair(pts[i][0], pts[i][1]);
  endtask

  task automatic test_random(int count);
    logic [15:0] y, x;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) no_idle = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 3))
        0: begin
          y = 16'($urandom_range(0, 8)) - 16'd4;
          x = 16'($urandom_range(0, 8)) - 16'd4;
        end
        1: begin
          // near the |y| = |x| diagonal, random signs
          y = 16'($urandom_range(0, 32767));
          x = y + 16'($urandom_range(0, 2)) - 16'd1;
          if ($urandom_range(0, 1)) y = -y;
          if ($urandom_range(0, 1)) x = -x;
        end
        default: begin
          y = 16'($urandom);
          x = 16'($urandom);
        end
      endcase
      send_pair(y, x);
    end
    no_idle = 1'b0;
  endtask

  // Stall the output for a long stretch while offering beats back to back.
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) send_pair(16'($urandom), 16'($urandom));
    no_idle = 1'b0;
  endtask

  // Pause input until every angle has come back, then resume.
  task automatic test_drain_pause();
    for (int i = 0; i < 50; i++) send_pair(16'($urandom), 16'($urandom));
    drain_wait();
    for (int i = 0; i < 50; i++) send_pair(16'($urandom), 16'($urandom));
  endtask

  // Result side: random stalls, the requested long hold, check in order.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (angle_queue.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected angle %0d", $signed(m_axis_tdata));
      end else begin
        logic [15:0] want;
        want = angle_queue.pop_front();
        if (want !== m_axis_tdata) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("angle mismatch: expected %0d got %0d",
                     $signed(want), $signed(m_axis_tdata));
        end
      end
    end
  end

  // Watchdog: cycles without any beat on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLim) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatch_cnt  = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1500);
    test_drain_pause();
    drain_wait();
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatch_cnt == 0 && angle_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/atan2_pkg.sv
src/atan2_div.sv
src/atan2_rational_approx_core.sv
tb/testbench.sv
